FILE: rtl/czs_pkg.sv
// Shared types, sizes and codes of the calorimeter hit zero-suppression core.
package czs_pkg;

  // Packet and tile geometry
  localparam int CHANNELS   = 144;
  localparam int TILE_SIZE  = 4;
  localparam int ROW_LENGTH = 12;
  localparam int WIDE_GAP   = 4;   // address gap inserted after each row in wide mode

  localparam int CNT_W  = $clog2(CHANNELS);
  localparam int TPOS_W = $clog2(TILE_SIZE);
  localparam int COL_W  = $clog2(ROW_LENGTH);

  // Decoupling queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int ADDR_W   = 16;
  localparam int OFFS_W   = 15;
  localparam int CTHR_W   = 13;
  localparam int SUM_W    = 19;
  localparam int CHE_W    = 17;   // channel energy: 13-bit difference times 16
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 19;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 96;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_THR  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_THR  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_OFFS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_ADDR = 4'd3;

  localparam logic signed [CTHR_W-1:0] CHAN_THR_RESET = -13'sd4096;

  // Record kinds
  localparam logic REC_CHANNEL = 1'b0;
  localparam logic REC_TILE    = 1'b1;

  typedef struct packed {
    logic signed [CTHR_W-1:0] chan_thr;
    logic signed [SUM_W-1:0]  tile_thr;
    logic [OFFS_W-1:0]        addr_offs;
    logic                     wide_addr;
  } czs_cfg_t;

  // One classified channel: up to two records waiting for the back end
  typedef struct packed {
    logic                     chan_hit;
    logic                     tile_hit;
    logic [ADDR_W-1:0]        chan_addr;
    logic [ADDR_W-1:0]        tile_addr;
    logic [SAMPLE_W-1:0]      time_v;
    logic [SAMPLE_W-1:0]      pre;
    logic [SAMPLE_W-1:0]      post;
    logic                     low_gain;
    logic signed [SUM_W-1:0]  chan_energy;
    logic signed [SUM_W-1:0]  tile_energy;
  } czs_entry_t;

  typedef struct packed {
    logic                     kind;
    logic [ADDR_W-1:0]        hit_address;
    logic [SAMPLE_W-1:0]      time_value;
    logic [SAMPLE_W-1:0]      high_post;
    logic [SAMPLE_W-1:0]      low_post;
    logic [SAMPLE_W-1:0]      high_pre;
    logic [SAMPLE_W-1:0]      low_pre;
    logic signed [SUM_W-1:0]  energy;
    logic                     last;
  } czs_record_t;

endpackage

FILE: rtl/czs_front.sv
// Front end: channel counting, thresholds, tile sums and address mapping.
module czs_front (
  input  logic                              clk,
  input  logic                              rst,
  input  czs_pkg::czs_cfg_t                 cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [czs_pkg::SAMPLE_W-1:0]      timing_word,
  input  logic [czs_pkg::SAMPLE_W-1:0]      pre_sample,
  input  logic [czs_pkg::SAMPLE_W:0]        post_word,
  input  logic                              packet_start,
  input  logic                              q_full,
  output logic                              q_push,
  output czs_pkg::czs_entry_t               q_entry
);
  import czs_pkg::*;

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        row;
  logic [COL_W-1:0]        col;
  logic [TPOS_W-1:0]       tpos;
  logic [CNT_W-1:0]        tidx;
  logic signed [SUM_W-1:0] tile_sum;

  logic [CNT_W-1:0]        cur_count, cur_row, cur_tidx;
  logic [COL_W-1:0]        cur_col;
  logic [TPOS_W-1:0]       cur_tpos;
  logic signed [SUM_W-1:0] cur_sum;

  logic                    low;
  logic [SAMPLE_W-1:0]     post;
  logic signed [CTHR_W-1:0] diff;
  logic signed [CHE_W-1:0] chan_e;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;
  logic                    chan_hit, tile_end, tile_hit, row_end, pkt_end;
  logic                    accept;
  logic [ADDR_W-1:0]       row_gap;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // A packet start clears the position and the running sum before this channel
  assign cur_count = packet_start ? '0 : count;
  assign cur_row   = packet_start ? '0 : row;
  assign cur_col   = packet_start ? '0 : col;
  assign cur_tpos  = packet_start ? '0 : tpos;
  assign cur_tidx  = packet_start ? '0 : tidx;
  assign cur_sum   = packet_start ? '0 : tile_sum;

  assign low  = post_word[SAMPLE_W];
  assign post = post_word[SAMPLE_W-1:0];
  assign diff = $signed({1'b0, pre_sample}) - $signed({1'b0, post});
  assign chan_e = low ? $signed({diff, 4'b0000}) : CHE_W'(diff);

  // Saturating tile accumulation
  assign sum_wide = (SUM_W+1)'(cur_sum) + (SUM_W+1)'(chan_e);
  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  assign chan_hit = low || (diff > cfg.chan_thr);
  assign tile_end = (cur_tpos == TPOS_W'(TILE_SIZE - 1));
  assign tile_hit = tile_end && (sum_sat > cfg.tile_thr);
  assign row_end  = (cur_col == COL_W'(ROW_LENGTH - 1));
  assign pkt_end  = (cur_count == CNT_W'(CHANNELS - 1));

  assign row_gap = cfg.wide_addr ? ADDR_W'(cur_row) * ADDR_W'(WIDE_GAP) : '0;

  always_comb begin
    q_entry.chan_hit    = chan_hit;
    q_entry.tile_hit    = tile_hit;
    q_entry.chan_addr   = ADDR_W'(cur_count) + ADDR_W'(cfg.addr_offs) + row_gap;
    q_entry.tile_addr   = ADDR_W'(cur_tidx) + ADDR_W'(cfg.addr_offs);
    q_entry.time_v      = timing_word;
    q_entry.pre         = pre_sample;
    q_entry.post        = post;
    q_entry.low_gain    = low;
    q_entry.chan_energy = SUM_W'(chan_e);
    q_entry.tile_energy = sum_sat;
  end

  assign q_push = accept && (chan_hit || tile_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      row      <= '0;
      col      <= '0;
      tpos     <= '0;
      tidx     <= '0;
      tile_sum <= '0;
    end else if (accept) begin
      if (pkt_end) begin
        // Wrap: drop any partial tile and start over
        count    <= '0;
        row      <= '0;
        col      <= '0;
        tpos     <= '0;
        tidx     <= '0;
        tile_sum <= '0;
      end else begin
        count    <= cur_count + 1'b1;
        col      <= row_end ? '0 : cur_col + 1'b1;
        row      <= row_end ? cur_row + 1'b1 : cur_row;
        tpos     <= tile_end ? '0 : cur_tpos + 1'b1;
        tidx     <= tile_end ? cur_tidx + 1'b1 : cur_tidx;
        tile_sum <= tile_end ? '0 : sum_sat;
      end
    end
  end

  a_count_in_packet: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CHANNELS - 1))
    else $error("channel count past packet end");

  a_sum_cleared_at_tile_end: assert property (@(posedge clk) disable iff (rst)
    accept && tile_end |=> tile_sum == '0)
    else $error("tile sum not cleared after tile end");

endmodule

FILE: rtl/czs_queue.sv
// Short register queue between the front and back ends.
module czs_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  czs_pkg::czs_entry_t  push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output czs_pkg::czs_entry_t  head
);
  import czs_pkg::*;

  czs_entry_t         slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  fill;

  assign full      = (fill == QCNT_W'(QDEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty))
    else $error("pop from empty queue");

endmodule

FILE: rtl/czs_back.sv
// Back end: splits queued entries into records and holds the output register.
module czs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_not_empty,
  input  czs_pkg::czs_entry_t  q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output czs_pkg::czs_record_t out_rec
);
  import czs_pkg::*;

  logic        second;     // channel record of the head entry already sent
  logic        load, use_tile;
  czs_record_t rec_next;

  assign load     = !out_valid || out_ready;
  assign use_tile = second || !q_head.chan_hit;
  assign q_pop    = load && q_not_empty && (use_tile || !q_head.tile_hit);

  always_comb begin
    rec_next.kind        = use_tile ? REC_TILE : REC_CHANNEL;
    rec_next.hit_address = use_tile ? q_head.tile_addr : q_head.chan_addr;
    rec_next.time_value  = use_tile ? '0 : q_head.time_v;
    rec_next.high_post   = (!use_tile && !q_head.low_gain) ? q_head.post : '0;
    rec_next.low_post    = (!use_tile &&  q_head.low_gain) ? q_head.post : '0;
    rec_next.high_pre    = (!use_tile && !q_head.low_gain) ? q_head.pre  : '0;
    rec_next.low_pre     = (!use_tile &&  q_head.low_gain) ? q_head.pre  : '0;
    rec_next.energy      = use_tile ? q_head.tile_energy : q_head.chan_energy;
    rec_next.last        = use_tile || !q_head.tile_hit;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rec <= rec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= q_not_empty;
      if (q_not_empty) begin
        second <= !use_tile && q_head.tile_hit;
      end
    end
  end

  a_second_has_entry: assert property (@(posedge clk) disable iff (rst)
    second |-> q_not_empty && q_head.tile_hit)
    else $error("second record pending without a tile entry");

endmodule

FILE: rtl/calorimeter_hit_zero_suppress_core.sv
// Top level of the calorimeter hit zero-suppression core.
//
//  channel   dir  data / user / last                         transfer when
//  s_axis    in   tdata: timing, pre, post word; tuser:      s_axis_tvalid & s_axis_tready
//                 packet start
//  m_axis    out  tdata: address, samples, energy; tuser:    m_axis_tvalid & m_axis_tready
//                 record kind; tlast: last record of input
//  cfg       in   cfg_index, cfg_data                        cfg_valid & cfg_ready
//
// One channel is taken per clock while the four-entry queue between the front and
// back ends has room; classification, tile summing and address mapping complete in
// the cycle of the transfer. The back end sends one record per clock while m_axis
// is not stalled, so a channel that yields both a hit and a tile record holds it
// until both are sent. A transfer is queued, then its first record loads the
// output register. rst is synchronous: it clears counters, the tile sum, the queue
// and out_valid, and restores the register defaults; there is no clearing pass.
// A stall on m_axis fills the queue, and s_axis_tready drops only when it is full.
module calorimeter_hit_zero_suppress_core (
  input  logic                               clk,
  input  logic                               rst,
  // s_axis tdata, low bit first: timing_word[11:0], pre_sample[11:0],
  // post_word[12:0], three unused bits
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [czs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // s_axis tuser: packet_start
  input  logic                               s_axis_tuser,
  // m_axis tdata, low bit first: hit_address[15:0], time_value[11:0],
  // high_post[11:0], low_post[11:0], high_pre[11:0], low_pre[11:0],
  // energy[18:0], one zero bit
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [czs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // m_axis tuser: record_kind
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast,
  // register write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [czs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [czs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import czs_pkg::*;

  czs_cfg_t    cfg;
  czs_entry_t  push_entry, head;
  czs_record_t out_rec;
  logic        q_full, q_push, q_pop, q_not_empty;

  // Register writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chan_thr  <= CHAN_THR_RESET;
      cfg.tile_thr  <= '0;
      cfg.addr_offs <= '0;
      cfg.wide_addr <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHAN_THR:  cfg.chan_thr  <= cfg_data[CTHR_W-1:0];
        CFG_TILE_THR:  cfg.tile_thr  <= cfg_data[SUM_W-1:0];
        CFG_ADDR_OFFS: cfg.addr_offs <= cfg_data[OFFS_W-1:0];
        CFG_WIDE_ADDR: cfg.wide_addr <= cfg_data[0];
        default: ;
      endcase
    end
  end

  czs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .timing_word  (s_axis_tdata[11:0]),
    .pre_sample   (s_axis_tdata[23:12]),
    .post_word    (s_axis_tdata[36:24]),
    .packet_start (s_axis_tuser),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  czs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  czs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (head),
    .q_pop       (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_rec     (out_rec)
  );

  // Pack the record; the top bit pads to whole bytes
  assign m_axis_tdata = {1'b0, out_rec.energy, out_rec.low_pre, out_rec.high_pre,
                         out_rec.low_post, out_rec.high_post, out_rec.time_value,
                         out_rec.hit_address};
  assign m_axis_tuser = out_rec.kind;
  assign m_axis_tlast = out_rec.last;

endmodule
